### rtl/slqp_pkg.sv
// Package for the lexicon engine: sizes, codes, and the types shared by its modules.
// Depends on nothing; every other file but slqp_if imports it.
`timescale 1ns / 1ps
`default_nettype none
package slqp_pkg;

	localparam int SLOT_COUNT  = 1024;
	localparam int STORE_BYTES = 16384;
	localparam int MAX_WORD    = 32;

	localparam int SLOT_W  = $clog2(SLOT_COUNT);
	localparam int N_W     = $clog2(SLOT_COUNT + 1);
	localparam int OFF_W   = $clog2(STORE_BYTES);
	localparam int FILL_W  = $clog2(STORE_BYTES + 1);
	localparam int LEN_W   = $clog2(MAX_WORD + 1);
	localparam int BUF_IW  = $clog2(MAX_WORD);
	localparam int SUM_W   = $clog2(MAX_WORD * 255 + 1);
	localparam int KEYV_W  = $clog2(MAX_WORD * 255 + 4 * SLOT_COUNT + 1);
	localparam int KCNT_W  = $clog2(KEYV_W);
	localparam int KIND_W  = 2;
	localparam int TBL_W   = KIND_W + OFF_W;
	localparam int CMP_W   = FILL_W + N_W + 4;
	localparam int PADDR_W = 3;

	// Operation codes carried with the last letter.
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_DELETED   = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_TBL_FULL  = 3'd5;
	localparam logic [2:0] ST_STO_FULL  = 3'd6;
	localparam logic [2:0] ST_TOO_LONG  = 3'd7;

	// Slot kinds; empty must be zero so that the clearing pass writes zeros.
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_USED    = 2'd2;

	// Register index of table_slots.
	localparam logic REG_TABLE_SLOTS = 1'b0;

	// One collected word handed from the front to the back.
	typedef struct packed {
		logic [1:0]       mode;
		logic [SUM_W-1:0] sum;
		logic [LEN_W-1:0] len;
		logic             too_long;
	} cmd_t;

	// Status from the back to the front.
	typedef struct packed {
		logic done;
		logic clearing;
	} bk_ctl_t;

endpackage
`default_nettype wire

### rtl/slqp_if.sv
// Handshake channels of the lexicon engine: letter words in, result words out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface slqp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] letter;
	logic       last;
	modport source(output valid, mode, letter, last, input ready);
	modport sink(input valid, mode, letter, last, output ready);
endinterface

interface slqp_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [9:0] slot;
	modport source(output valid, status, slot, input ready);
	modport sink(input valid, status, slot, output ready);
endinterface
`default_nettype wire

### rtl/slqp_front.sv
// Front part: collects letters into the word buffer and hands finished words to the queue.
// Depends on slqp_pkg and slqp_if.
`timescale 1ns / 1ps
`default_nettype none
module slqp_front
	import slqp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	slqp_req_if.sink               req,
	input  wire bk_ctl_t           ctl,
	input  wire logic              q_full,
	output logic                   q_push,
	output cmd_t                   q_data,
	input  wire logic [BUF_IW-1:0] rd_idx,
	output logic [7:0]             rd_data
);

	logic [7:0]       buf_q [MAX_WORD];
	logic [LEN_W-1:0] len_q, len_nx;
	logic [SUM_W-1:0] sum_q, sum_nx;
	logic             tl_q, tl_nx, lock_q, acc, add_ok;

	// A word stays locked in the buffer until the back has answered it.
	assign req.ready = !lock_q && !ctl.clearing && !q_full;
	assign acc       = req.valid && req.ready;
	assign add_ok    = (req.letter != 8'd0) && (len_q < LEN_W'(MAX_WORD));
	assign rd_data   = buf_q[rd_idx];

	// Next values of the collector after this letter.
	always_comb begin
		len_nx = len_q;
		sum_nx = sum_q;
		tl_nx  = tl_q;
		if (req.letter != 8'd0) begin
			if (add_ok) begin
				len_nx = len_q + LEN_W'(1);
				sum_nx = sum_q + SUM_W'(req.letter);
			end else begin
				tl_nx = 1'b1;
			end
		end
	end

	assign q_push        = acc && req.last;
	assign q_data.mode     = req.mode;
	assign q_data.sum      = sum_nx;
	assign q_data.len      = len_nx;
	assign q_data.too_long = tl_nx;

	// Letter storage.
	always_ff @(posedge clk) begin
		if (acc && add_ok) begin
			buf_q[len_q[BUF_IW-1:0]] <= req.letter;
		end
	end

	// Collector and lock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			sum_q  <= '0;
			tl_q   <= 1'b0;
			lock_q <= 1'b0;
		end else begin
			if (acc) begin
				if (req.last) begin
					len_q  <= '0;
					sum_q  <= '0;
					tl_q   <= 1'b0;
					lock_q <= 1'b1;
				end else begin
					len_q <= len_nx;
					sum_q <= sum_nx;
					tl_q  <= tl_nx;
				end
			end else if (ctl.done) begin
				lock_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/slqp_queue.sv
// Two-entry queue of collected words between the front and the back.
// Depends on slqp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slqp_queue
	import slqp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty,
	output logic      full
);

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign rdata = ent_q[rp_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= !wp_q;
			end
			if (pop && !empty) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule
`default_nettype wire

### rtl/slqp_back.sv
// Back part: key remainder, quadratic probe walk, string compare, insert and delete.
// Holds the slot table and the character store; depends on slqp_pkg and slqp_if.
`timescale 1ns / 1ps
`default_nettype none
module slqp_back
	import slqp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [N_W-1:0]    n,
	input  wire logic              clr_start,
	input  wire logic              q_empty,
	input  wire cmd_t              q_data,
	output logic                   q_pop,
	output logic [BUF_IW-1:0]      rd_idx,
	input  wire logic [7:0]        rd_data,
	output bk_ctl_t                ctl,
	slqp_rsp_if.source             rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_CMPR = 3'd4;
	localparam logic [2:0] S_CMPW = 3'd5;
	localparam logic [2:0] S_WR   = 3'd6;
	localparam logic [2:0] S_RES  = 3'd7;

	logic [TBL_W-1:0]  tbl_mem [SLOT_COUNT];
	logic [7:0]        sto_mem [STORE_BYTES];
	logic [TBL_W-1:0]  tbl_rd_q;
	logic [7:0]        sto_rd_q;

	logic [2:0]        st_q;
	logic [1:0]        mode_q;
	logic [LEN_W-1:0]  len_q, j_q;
	logic              tl_q;
	logic [KEYV_W-1:0] v_q;
	logic [KCNT_W-1:0] kcnt_q;
	logic [N_W-1:0]    rem_q, p_q, d_q, i_q;
	logic [OFF_W-1:0]  off_q;
	logic [FILL_W-1:0] fill_q;
	logic              clr_q;
	logic [SLOT_W-1:0] clr_idx_q;
	logic [2:0]        res_st_q;
	logic [9:0]        res_slot_q;
	logic              ov_q;
	logic [2:0]        ost_q;
	logic [9:0]        oslot_q;

	logic [N_W:0]      rem_sh, rem_sub, p_add, d_add, d_a;
	logic [N_W-1:0]    rem_nx, p_nx, d_nx, i_nx;
	logic              j_end, is_ins, is_del, match, load_out, room_ok;
	logic [7:0]        exp_char;
	logic [KIND_W-1:0] kind;
	logic [CMP_W-1:0]  cap, cap15, fill_need;
	logic              tbl_we;
	logic [SLOT_W-1:0] tbl_wa;
	logic [TBL_W-1:0]  tbl_wd;
	logic              sto_we;
	logic [OFF_W-1:0]  sto_wa, sto_ra;

	assign is_ins   = (mode_q == MODE_INSERT);
	assign is_del   = (mode_q == MODE_DELETE);
	assign j_end    = (j_q == len_q);
	assign rd_idx   = j_q[BUF_IW-1:0];
	assign exp_char = j_end ? 8'd0 : rd_data;
	assign match    = (sto_rd_q == exp_char);
	assign kind     = tbl_rd_q[TBL_W-1 -: KIND_W];
	assign load_out = (st_q == S_RES) && (!ov_q || rsp.ready);

	// One restoring step of the key remainder.
	always_comb begin
		rem_sh  = {rem_q, v_q[KEYV_W-1]};
		rem_sub = rem_sh - {1'b0, n};
		rem_nx  = (rem_sh >= {1'b0, n}) ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
	end

	// Next probe: slot advances by a step that grows by two each probe, reduced modulo n.
	always_comb begin
		p_add = {1'b0, p_q} + {1'b0, d_q};
		p_nx  = (p_add >= {1'b0, n}) ? N_W'(p_add - {1'b0, n}) : p_add[N_W-1:0];
		d_add = {1'b0, d_q} + (N_W+1)'(2);
		d_a   = (d_add >= {1'b0, n}) ? d_add - {1'b0, n} : d_add;
		d_nx  = (d_a >= {1'b0, n}) ? N_W'(d_a - {1'b0, n}) : d_a[N_W-1:0];
		i_nx  = i_q + N_W'(1);
	end

	// Store capacity is the lesser of fifteen bytes per slot and the store size.
	always_comb begin
		cap15     = CMP_W'({n, 4'b0000}) - CMP_W'(n);
		cap       = (cap15 > CMP_W'(STORE_BYTES)) ? CMP_W'(STORE_BYTES) : cap15;
		fill_need = CMP_W'(fill_q) + CMP_W'(len_q) + CMP_W'(1);
		room_ok   = (fill_need <= cap);
	end

	// Write ports of the two memories.
	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = p_q[SLOT_W-1:0];
		tbl_wd = {KIND_DELETED, off_q};
		if (clr_q) begin
			tbl_we = 1'b1;
			tbl_wa = clr_idx_q;
			tbl_wd = {KIND_EMPTY, {OFF_W{1'b0}}};
		end else if (st_q == S_WR && j_end) begin
			tbl_we = 1'b1;
			tbl_wd = {KIND_USED, fill_q[OFF_W-1:0]};
		end else if (st_q == S_CMPW && match && j_end && is_del) begin
			tbl_we = 1'b1;
		end
		sto_we = (st_q == S_WR);
		sto_wa = fill_q[OFF_W-1:0] + OFF_W'(j_q);
		sto_ra = off_q + OFF_W'(j_q);
	end

	// Slot table.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		tbl_rd_q <= tbl_mem[p_q[SLOT_W-1:0]];
	end

	// Character store.
	always_ff @(posedge clk) begin
		if (sto_we) begin
			sto_mem[sto_wa] <= exp_char;
		end
		sto_rd_q <= sto_mem[sto_ra];
	end

	assign q_pop        = (st_q == S_IDLE) && !clr_q && !q_empty;
	assign ctl.done     = load_out;
	assign ctl.clearing = clr_q;
	assign rsp.valid    = ov_q;
	assign rsp.status   = ost_q;
	assign rsp.slot     = oslot_q;

	// Sequencer of one word's operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			mode_q     <= MODE_INSERT;
			len_q      <= '0;
			j_q        <= '0;
			tl_q       <= 1'b0;
			v_q        <= '0;
			kcnt_q     <= '0;
			rem_q      <= '0;
			p_q        <= '0;
			d_q        <= '0;
			i_q        <= '0;
			off_q      <= '0;
			fill_q     <= '0;
			clr_q      <= 1'b1;
			clr_idx_q  <= '0;
			res_st_q   <= ST_NOT_FOUND;
			res_slot_q <= '0;
		end else begin
			if (clr_start) begin
				clr_q     <= 1'b1;
				clr_idx_q <= '0;
				fill_q    <= '0;
			end else if (clr_q) begin
				clr_idx_q <= clr_idx_q + SLOT_W'(1);
				if (clr_idx_q == SLOT_W'(SLOT_COUNT - 1)) begin
					clr_q <= 1'b0;
				end
			end
			case (st_q)
				S_IDLE: begin
					if (q_pop) begin
						mode_q <= q_data.mode;
						len_q  <= q_data.len;
						tl_q   <= q_data.too_long;
						v_q    <= KEYV_W'(q_data.sum) + KEYV_W'({n, 2'b00}) - KEYV_W'(4);
						kcnt_q <= KCNT_W'(KEYV_W - 1);
						rem_q  <= '0;
						st_q   <= S_MOD;
					end
				end
				S_MOD: begin
					rem_q <= rem_nx;
					v_q   <= {v_q[KEYV_W-2:0], 1'b0};
					if (kcnt_q == '0) begin
						p_q <= rem_nx;
						d_q <= (n == N_W'(1)) ? N_W'(0) : N_W'(1);
						i_q <= '0;
						if (tl_q) begin
							res_st_q   <= ST_TOO_LONG;
							res_slot_q <= '0;
							st_q       <= S_RES;
						end else begin
							st_q <= S_RD;
						end
					end else begin
						kcnt_q <= kcnt_q - KCNT_W'(1);
					end
				end
				S_RD: begin
					st_q <= S_EVAL;
				end
				S_EVAL: begin
					j_q <= '0;
					if (kind == KIND_EMPTY) begin
						if (!is_ins) begin
							res_st_q   <= ST_NOT_FOUND;
							res_slot_q <= '0;
							st_q       <= S_RES;
						end else if (!room_ok) begin
							res_st_q   <= ST_STO_FULL;
							res_slot_q <= '0;
							st_q       <= S_RES;
						end else begin
							st_q <= S_WR;
						end
					end else if (kind == KIND_USED) begin
						off_q <= tbl_rd_q[OFF_W-1:0];
						st_q  <= S_CMPR;
					end else if (i_nx == n) begin
						res_st_q   <= is_ins ? ST_TBL_FULL : ST_NOT_FOUND;
						res_slot_q <= '0;
						st_q       <= S_RES;
					end else begin
						p_q  <= p_nx;
						d_q  <= d_nx;
						i_q  <= i_nx;
						st_q <= S_RD;
					end
				end
				S_CMPR: begin
					st_q <= S_CMPW;
				end
				S_CMPW: begin
					if (match && j_end) begin
						res_slot_q <= 10'(p_q);
						res_st_q   <= is_ins ? ST_PRESENT : (is_del ? ST_DELETED : ST_FOUND);
						st_q       <= S_RES;
					end else if (match) begin
						j_q  <= j_q + LEN_W'(1);
						st_q <= S_CMPR;
					end else if (i_nx == n) begin
						res_st_q   <= is_ins ? ST_TBL_FULL : ST_NOT_FOUND;
						res_slot_q <= '0;
						st_q       <= S_RES;
					end else begin
						p_q  <= p_nx;
						d_q  <= d_nx;
						i_q  <= i_nx;
						st_q <= S_RD;
					end
				end
				S_WR: begin
					if (j_end) begin
						fill_q     <= FILL_W'(fill_need);
						res_st_q   <= ST_INSERTED;
						res_slot_q <= 10'(p_q);
						st_q       <= S_RES;
					end else begin
						j_q <= j_q + LEN_W'(1);
					end
				end
				S_RES: begin
					if (load_out) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: holds a result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			ost_q   <= ST_NOT_FOUND;
			oslot_q <= '0;
		end else begin
			if (load_out) begin
				ov_q    <= 1'b1;
				ost_q   <= res_st_q;
				oslot_q <= res_slot_q;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/string_lexicon_quadratic_probe_top.sv
// Operation: a last letter starts the key remainder in S_MOD (one bit a cycle); each
// probe then reads its slot in S_RD and S_EVAL, each compared stored word is walked
// letter by letter in S_CMPR and S_CMPW, and an insert appends the word in S_WR.
// Throughput: one word at a time; the front takes the next word after the result is out.
// Reset clears control state and then runs a clearing pass over every slot of the
// table, during which no word is taken; a table_slots write starts the same pass.
`timescale 1ns / 1ps
`default_nettype none
module string_lexicon_quadratic_probe_top
	import slqp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	slqp_req_if.sink                req,
	slqp_rsp_if.source              rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [N_W-1:0]    tslots_q, wr_val;
	logic              cfg_wr, q_push, q_pop, q_empty, q_full;
	cmd_t              q_wdata, q_rdata;
	bk_ctl_t           ctl;
	logic [BUF_IW-1:0] rd_idx;
	logic [7:0]        rd_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TABLE_SLOTS);
	assign prdata = (paddr[2] == REG_TABLE_SLOTS) ? 32'(tslots_q) : 32'd0;

	// Slot count is held between one and the table size.
	always_comb begin
		wr_val = N_W'(pwdata[10:0]);
		if (pwdata[10:0] == 11'd0) begin
			wr_val = N_W'(1);
		end else if (pwdata[10:0] > 11'(SLOT_COUNT)) begin
			wr_val = N_W'(SLOT_COUNT);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tslots_q <= N_W'(SLOT_COUNT);
		end else if (cfg_wr) begin
			tslots_q <= wr_val;
		end
	end

	slqp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.ctl     (ctl),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wdata),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	slqp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	slqp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (tslots_q),
		.clr_start (cfg_wr),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.ctl       (ctl),
		.rsp       (rsp)
	);

	// A failed or rejected word never names a slot.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_TBL_FULL ||
		rsp.status == ST_STO_FULL || rsp.status == ST_TOO_LONG) |-> rsp.slot == 10'd0)
		else $error("slot set on a failed result");

	// A reported slot lies inside the table in use.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> N_W'(rsp.slot) < tslots_q)
		else $error("slot outside the table");

	// No word is taken while the table is being cleared.
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> !req.ready)
		else $error("word taken during clearing");

	// The front never pushes into a full queue.
	a_queue_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overflow");

endmodule
`default_nettype wire
